// ----- hdl/assert_macros.svh -----
// assertion macros shared by the allocator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("assertion failed");
`define ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_NEVER(lbl, cond)
`define ASSERT_IMPLY(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- hdl/fba_pkg.sv -----
`timescale 1ns / 1ps
// types and constants of the free block bitmap allocator
package fba_pkg;

  localparam int unsigned STATUS_W = 2;
  localparam int unsigned BLK_W    = 12;
  localparam int unsigned CNT_P_W  = 13;
  localparam int unsigned WANT_W   = 5;
  localparam int unsigned ROW_BITS = 8;
  localparam int unsigned ROW_SH   = 3;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_FREE,
    S_ALLOC
  } fba_state_e;

endpackage

// ----- hdl/free_block_bitmap_allocator.sv -----
`timescale 1ns / 1ps
// first fit block allocator over a used/free bitmap held in a row memory
// free request: the row is read, then S_FREE decides and registers the result; rejected
// allocate: result in the cycle after accept; allocate: rows read from row 0 up, one block
//   granted per cycle while the row has a free block, else the row written back and the
//   next fetched (one read port); after reset and each block_count write a clear pass
//   zeroes every row with busy high; results come at most one per cycle and cannot be stalled
`include "assert_macros.svh"

module free_block_bitmap_allocator
  import fba_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS = 4096,
  parameter int unsigned MAX_ALLOC  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // block_count register
  input  logic                cfg_we_i,
  input  logic [CNT_P_W-1:0]  cfg_wdata_i,
  // request side
  input  logic                start,
  output logic                busy,
  input  logic                req_type_i,
  input  logic [WANT_W-1:0]   want_count_i,
  input  logic [BLK_W-1:0]    block_index_i,
  // result side
  output logic                res_valid_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [BLK_W-1:0]    granted_block_o,
  output logic                last_o,
  output logic [CNT_P_W-1:0]  free_blocks_o
);

  // map geometry: one memory row holds the used bits of 8 consecutive blocks
  localparam int unsigned IDX_W = $clog2(NUM_BLOCKS);
  localparam int unsigned CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned ROWS  = (NUM_BLOCKS + ROW_BITS - 1) / ROW_BITS;
  localparam int unsigned ROW_W = (IDX_W > ROW_SH + 1) ? IDX_W - ROW_SH : 1;
  localparam int unsigned REM_W = $clog2(MAX_ALLOC + 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

  // map memory, one write and one read port, registered read data
  logic [ROW_BITS-1:0] map_mem [ROWS];
  logic [ROW_BITS-1:0] rd_data_q;
  logic                mem_we, mem_re;
  logic [ROW_W-1:0]    mem_waddr, mem_raddr;
  logic [ROW_BITS-1:0] mem_wdata;

  // control and payload registers
  fba_state_e          state_q, state_d;
  logic [ROW_W-1:0]    clr_q, clr_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [ROW_SH-1:0]   bit_q, bit_d;
  logic                hit_q, hit_d;
  logic [ROW_BITS-1:0] word_q, word_d;
  logic                fresh_q, fresh_d;
  logic [REM_W-1:0]    rem_q, rem_d;
  logic [CNT_W-1:0]    free_q, free_d;
  logic [CNT_W-1:0]    managed_q, managed_d;
  logic                strobe_q, strobe_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [BLK_W-1:0]    gblk_q, gblk_d;
  logic                last_q, last_d;

  // scan helpers
  logic [ROW_BITS-1:0] word_cur;
  logic [ROW_BITS-1:0] avail;
  logic [ROW_BITS-1:0] cand;
  logic [ROW_SH-1:0]   pick;
  logic [31:0]         row_base;
  logic [31:0]         in_idx32;
  logic [31:0]         in_row32;
  logic [31:0]         sat32;
  logic [31:0]         fsub32;
  logic [31:0]         gblk32;
  logic                accept;
  logic                want_bad;
  logic                no_space;

  assign accept   = start && !busy;
  assign in_idx32 = 32'(block_index_i);
  assign in_row32 = in_idx32 >> ROW_SH;
  assign want_bad = (want_count_i == '0) || (32'(want_count_i) > MAX_ALLOC);
  assign no_space = 32'(free_q) < 32'(want_count_i);
  assign fsub32   = 32'(free_q) - 32'(want_count_i);
  assign sat32    = (32'(cfg_wdata_i) > NUM_BLOCKS) ? NUM_BLOCKS : 32'(cfg_wdata_i);

  // the row word just read is taken from the memory, later picks from the working copy
  assign word_cur = fresh_q ? rd_data_q : word_q;
  assign row_base = 32'(row_q) << ROW_SH;
  assign gblk32   = row_base | 32'(pick);

  // blocks at or above the managed count never count as free
  always_comb begin
    for (int b = 0; b < ROW_BITS; b++) begin
      avail[b] = (row_base + 32'(b)) < 32'(managed_q);
    end
  end

  assign cand = ~word_cur & avail;

  // lowest free bit of the row
  always_comb begin
    pick = '0;
    for (int b = ROW_BITS - 1; b >= 0; b--) begin
      if (cand[b]) begin
        pick = ROW_SH'(b);
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    row_d     = row_q;
    bit_d     = bit_q;
    hit_d     = hit_q;
    word_d    = word_q;
    fresh_d   = 1'b0;
    rem_d     = rem_q;
    free_d    = free_q;
    managed_d = managed_q;
    strobe_d  = 1'b0;
    status_d  = status_q;
    gblk_d    = gblk_q;
    last_d    = last_q;
    mem_we    = 1'b0;
    mem_waddr = row_q;
    mem_wdata = word_cur;
    mem_re    = 1'b0;
    mem_raddr = row_q;

    case (state_q)
      S_CLEAR: begin
        // one row zeroed per cycle
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        if (clr_q == ROW_LAST) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (req_type_i == REQ_FREE) begin
            // fetch the row, decide on the next cycle
            mem_re    = 1'b1;
            mem_raddr = in_row32[ROW_W-1:0];
            row_d     = in_row32[ROW_W-1:0];
            bit_d     = in_idx32[ROW_SH-1:0];
            hit_d     = in_idx32 < 32'(managed_q);
            state_d   = S_FREE;
          end else if (want_bad) begin
            strobe_d = 1'b1;
            status_d = ST_INVALID;
            gblk_d   = '0;
            last_d   = 1'b1;
          end else if (no_space) begin
            strobe_d = 1'b1;
            status_d = ST_NOSPACE;
            gblk_d   = '0;
            last_d   = 1'b1;
          end else begin
            // success is certain: the free count drops by the whole request now
            free_d    = fsub32[CNT_W-1:0];
            rem_d     = REM_W'(want_count_i);
            row_d     = '0;
            mem_re    = 1'b1;
            mem_raddr = '0;
            fresh_d   = 1'b1;
            state_d   = S_ALLOC;
          end
        end
      end
      S_FREE: begin
        if (hit_q && rd_data_q[bit_q]) begin
          mem_we    = 1'b1;
          mem_waddr = row_q;
          mem_wdata = rd_data_q & ~(ROW_BITS'(1) << bit_q);
          free_d    = free_q + 1'b1;
        end
        strobe_d = 1'b1;
        status_d = ST_OK;
        gblk_d   = '0;
        last_d   = 1'b1;
        state_d  = S_IDLE;
      end
      S_ALLOC: begin
        if (|cand) begin
          // grant one block per cycle while the row still has a free block
          word_d   = word_cur | (ROW_BITS'(1) << pick);
          strobe_d = 1'b1;
          status_d = ST_OK;
          gblk_d   = gblk32[BLK_W-1:0];
          last_d   = (rem_q == REM_W'(1));
          rem_d    = rem_q - 1'b1;
          if (rem_q == REM_W'(1)) begin
            mem_we    = 1'b1;
            mem_waddr = row_q;
            mem_wdata = word_d;
            state_d   = S_IDLE;
          end
        end else begin
          // row exhausted: write it back and fetch the next one
          mem_we    = 1'b1;
          mem_waddr = row_q;
          mem_wdata = word_cur;
          row_d     = row_q + 1'b1;
          mem_re    = 1'b1;
          mem_raddr = row_q + 1'b1;
          fresh_d   = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // a block_count write restarts the map from scratch
    if (cfg_we_i) begin
      managed_d = sat32[CNT_W-1:0];
      free_d    = sat32[CNT_W-1:0];
      clr_d     = '0;
      state_d   = S_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      fresh_q   <= 1'b0;
      rem_q     <= '0;
      free_q    <= '0;
      managed_q <= '0;
      strobe_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      fresh_q   <= fresh_d;
      rem_q     <= rem_d;
      free_q    <= free_d;
      managed_q <= managed_d;
      strobe_q  <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q    <= row_d;
    bit_q    <= bit_d;
    hit_q    <= hit_d;
    word_q   <= word_d;
    status_q <= status_d;
    gblk_q   <= gblk_d;
    last_q   <= last_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= map_mem[mem_raddr];
    end
  end

  assign busy            = (state_q != S_IDLE);
  assign res_valid_o     = strobe_q;
  assign status_o        = status_q;
  assign granted_block_o = gblk_q;
  assign last_o          = last_q;
  // free count is final by the time any result of a request is shown
  assign free_blocks_o   = CNT_P_W'(32'(free_q));

  `ASSERT_NEVER(a_free_le_managed, free_q > managed_q)
  `ASSERT_IMPLY(a_alloc_rem_nonzero, state_q == S_ALLOC, rem_q != '0)
  `ASSERT_IMPLY(a_error_is_last, strobe_q && (status_q != ST_OK), last_q)
  `ASSERT_NEXT(a_accept_progress, accept && !cfg_we_i, busy || strobe_q)

endmodule

// ----- test/free_block_bitmap_allocator_test.sv -----
`timescale 1ns / 1ps
// self-checking testbench of the first fit free block bitmap allocator
module free_block_bitmap_allocator_test
  import fba_pkg::*;
();

  localparam int unsigned NUM_BLOCKS  = 4096;
  localparam int unsigned MAX_ALLOC   = 16;
  // longest quiet stretch of a correct run is a clear pass or a full map scan
  localparam int          STALL_LIMIT = 4000;
  // a free answers once its row has been read; watch a while longer for stray results
  localparam int          TAIL_CYCLES = 40;
  localparam int          MAX_SHOWN   = 10;

  // one result as the block should present it
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BLK_W-1:0]    granted;
    logic                last;
    logic [CNT_P_W-1:0]  free_cnt;
  } reply_t;

  // every input known from time zero
  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CNT_P_W-1:0]  cfg_wdata_i   = '0;
  logic                start         = 1'b0;
  logic                busy;
  logic                req_type_i    = REQ_ALLOC;
  logic [WANT_W-1:0]   want_count_i  = '0;
  logic [BLK_W-1:0]    block_index_i = '0;
  logic                res_valid_o;
  logic [STATUS_W-1:0] status_o;
  logic [BLK_W-1:0]    granted_block_o;
  logic                last_o;
  logic [CNT_P_W-1:0]  free_blocks_o;

  always #6 clk_i = ~clk_i;

  free_block_bitmap_allocator #(
    .NUM_BLOCKS(NUM_BLOCKS),
    .MAX_ALLOC (MAX_ALLOC)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .want_count_i   (want_count_i),
    .block_index_i  (block_index_i),
    .res_valid_o    (res_valid_o),
    .status_o       (status_o),
    .granted_block_o(granted_block_o),
    .last_o         (last_o),
    .free_blocks_o  (free_blocks_o)
  );

  // shadow of the allocator: used bits, managed block count, free count
  bit     blk_used [NUM_BLOCKS];
  int     managed_blocks = 0;
  int     free_left      = 0;
  // results owed by the block, oldest first
  reply_t replies_due [$];
  reply_t due_r;

  int burst_left    = 0;
  int mismatches    = 0;
  int results_seen  = 0;
  int requests_sent = 0;
  int grants        = 0;
  int nospace_cnt   = 0;
  int invalid_cnt   = 0;
  int released_cnt  = 0;
  int stall_cycles  = 0;

  // queue one result; every result carries the free count after the request
  function automatic void push_reply(input logic [STATUS_W-1:0] st, input int blk,
                                     input logic lst);
    reply_t r;
    r.status   = st;
    r.granted  = BLK_W'(blk);
    r.last     = lst;
    r.free_cnt = CNT_P_W'(free_left);
    replies_due.insert(replies_due.size(), r);
  endfunction

  // block_count write: saturate to the map size and clear the map
  function automatic void apply_block_count(input int value);
    managed_blocks = (value > int'(NUM_BLOCKS)) ? int'(NUM_BLOCKS) : value;
    foreach (blk_used[i]) blk_used[i] = 1'b0;
    free_left = managed_blocks;
  endfunction

  // expected results of one accepted request
  function automatic void predict_request(input logic rt, input logic [WANT_W-1:0] want,
                                          input logic [BLK_W-1:0] idx);
    int picks [MAX_ALLOC];
    int got;
    requests_sent++;
    if (rt == REQ_FREE) begin
      // out of range or already free: nothing changes, still success
      if (int'(idx) < managed_blocks && blk_used[idx]) begin
        blk_used[idx] = 1'b0;
        free_left++;
        released_cnt++;
      end
      push_reply(ST_OK, 0, 1'b1);
    end else if (want == 0 || want > MAX_ALLOC) begin
      invalid_cnt++;
      push_reply(ST_INVALID, 0, 1'b1);
    end else if (free_left < int'(want)) begin
      // all or nothing: map untouched
      nospace_cnt++;
      push_reply(ST_NOSPACE, 0, 1'b1);
    end else begin
      // lowest numbered free blocks first
      got = 0;
      for (int i = 0; i < managed_blocks && got < int'(want); i++) begin
        if (!blk_used[i]) begin
          blk_used[i] = 1'b1;
          picks[got]  = i;
          got++;
        end
      end
      free_left -= got;
      grants    += got;
      for (int k = 0; k < got; k++) push_reply(ST_OK, picks[k], k == got - 1);
    end
  endfunction

  // some block that is in use, searched from a random point
  function automatic int pick_used_block();
    int first;
    int idx;
    first = $urandom_range(0, managed_blocks - 1);
    for (int k = 0; k < managed_blocks; k++) begin
      idx = (first + k) % managed_blocks;
      if (blk_used[idx]) return idx;
    end
    return first;
  endfunction

  // one request: random hold-off (or none inside a burst), then wait for accept
  task automatic send_request(input logic rt, input int want, input int idx);
    int gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = $urandom_range(0, 12);
      if ($urandom_range(0, 9) == 0) burst_left = $urandom_range(4, 12);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start         <= 1'b1;
    req_type_i    <= rt;
    want_count_i  <= WANT_W'(want);
    block_index_i <= BLK_W'(idx);
    do @(posedge clk_i); while (busy);
    predict_request(rt, WANT_W'(want), BLK_W'(idx));
  endtask

  // stop sending until every owed result is in and the block is idle
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (replies_due.size() != 0 || busy);
  endtask

  task automatic set_block_count(input int value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CNT_P_W'(value);
    @(posedge clk_i);
    apply_block_count(value);
    cfg_we_i    <= 1'b0;
  endtask

  // random request; frees lean on used blocks, and dominate when the map runs full
  task automatic random_request();
    int roll;
    int sub;
    int want;
    int idx;
    int free_pct;
    free_pct = (managed_blocks > 0 && free_left * 4 < managed_blocks) ? 65 : 35;
    roll = $urandom_range(0, 99);
    sub  = $urandom_range(0, 19);
    if (roll < free_pct) begin
      if (sub < 14 && free_left < managed_blocks) idx = pick_used_block();
      else if (sub < 18) idx = $urandom_range(0, (managed_blocks + 8 > 4095) ? 4095
                                                  : managed_blocks + 8);
      else idx = $urandom_range(0, 4095);
      // want field is don't care on a free, keep it toggling
      send_request(REQ_FREE, $urandom_range(0, 31), idx);
    end else begin
      if (sub == 0) want = 0;
      else if (sub == 1) want = $urandom_range(MAX_ALLOC + 1, 31);
      else if (sub < 11) want = $urandom_range(1, 4);
      else want = $urandom_range(1, MAX_ALLOC);
      send_request(REQ_ALLOC, want, $urandom_range(0, 4095));
    end
  endtask

  // block count is zero after reset: every valid allocate lacks space, every free is ignored
  task automatic test_reset_state();
    send_request(REQ_ALLOC, 1, 0);
    send_request(REQ_ALLOC, 0, 0);
    send_request(REQ_FREE, 0, 0);
    send_request(REQ_FREE, 31, 4095);
  endtask

  // oversized count saturates; largest, smallest, zero and oversized allocates, frees of an unused and a used block
  task automatic test_request_sizes();
    set_block_count(8191);
    send_request(REQ_ALLOC, MAX_ALLOC, 0);
    send_request(REQ_ALLOC, 1, 0);
    send_request(REQ_ALLOC, 0, 4095);
    send_request(REQ_ALLOC, MAX_ALLOC + 1, 0);
    send_request(REQ_ALLOC, 31, 0);
    send_request(REQ_FREE, 0, 4095);
    send_request(REQ_FREE, 0, 3);
    send_request(REQ_ALLOC, 2, 0);
  endtask

  // map that spans two rows: run it dry, free out of range, free twice, refill
  task automatic test_small_map();
    set_block_count(9);
    send_request(REQ_ALLOC, 8, 0);
    send_request(REQ_ALLOC, 2, 0);
    send_request(REQ_ALLOC, 1, 0);
    send_request(REQ_ALLOC, 1, 0);
    send_request(REQ_FREE, 0, 9);
    send_request(REQ_FREE, 0, 0);
    send_request(REQ_FREE, 0, 0);
    send_request(REQ_ALLOC, 1, 0);
  endtask

  task automatic test_random_traffic(input int count, input int n_items);
    set_block_count(count);
    repeat (n_items) random_request();
  endtask

  // a back to back burst, then hold the sender until the block has answered all
  task automatic test_pause_until_drained();
    set_block_count(16);
    burst_left = 12;
    repeat (12) random_request();
    wait_drained();
    repeat (12) random_request();
  endtask

  // result checker: each result against the oldest owed one
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      results_seen++;
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected result: status %0d block %0d last %0d free %0d",
                   status_o, granted_block_o, last_o, free_blocks_o);
      end else begin
        due_r = replies_due.pop_front();
        if (status_o !== due_r.status || granted_block_o !== due_r.granted ||
            last_o !== due_r.last || free_blocks_o !== due_r.free_cnt) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("result %0d: expected st %0d blk %0d last %0d free %0d, got %0d %0d %0d %0d",
                     results_seen, due_r.status, due_r.granted, due_r.last, due_r.free_cnt,
                     status_o, granted_block_o, last_o, free_blocks_o);
        end
      end
    end
  end

  // watchdog: too long with no request, result or register write means a hang
  initial begin
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((start && !busy) || res_valid_o || cfg_we_i) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("timeout after %0d idle cycles", STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_request_sizes();
    test_small_map();
    test_random_traffic(0, 15);
    test_random_traffic(1, 30);
    test_random_traffic(8, 60);
    test_random_traffic(24, 90);
    test_random_traffic($urandom_range(9, 200), 90);
    test_pause_until_drained();
    test_random_traffic(37, 60);
    test_random_traffic(NUM_BLOCKS, 60);

    // everything owed has arrived; keep watching for strays
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("run covered %0d requests and %0d results: %0d blocks granted, %0d released",
             requests_sent, results_seen, grants, released_cnt);
    $display("rejected allocates: %0d short of space, %0d bad size; mismatches %0d",
             nospace_cnt, invalid_cnt, mismatches);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/fba_pkg.sv
hdl/free_block_bitmap_allocator.sv
test/free_block_bitmap_allocator_test.sv
